/* design/whd_pkg.sv */
// Package for the wire hit declusterer: field widths, register codes, reset values,
// the cluster command that the front hands to the back, and the state machine types.
// No dependencies.
package whd_pkg;

	localparam int IDX_W   = 12;
	localparam int PLANE_W = 6;
	localparam int WIRE_W  = 8;
	localparam int TIME_W  = 16;
	localparam int POS_W   = 21;
	localparam int DRIFT_W = 12;
	localparam int GAP_W   = 20;
	localparam int DPOS_W  = POS_W + 1;

	localparam int MAX_CLUSTER = 16;
	localparam int CNT_W       = $clog2(MAX_CLUSTER + 1);

	// Ring of hit indices shared by the open cluster and all queued clusters.
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// Command queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_PAIR_TIME_WINDOW   = 3'd0,
		REG_NOISE_GAP_MEAN     = 3'd1,
		REG_LAST_CHAMBER_PLANE = 3'd2,
		REG_PAIR_PLANE_LOW     = 3'd3,
		REG_PAIR_PLANE_HIGH    = 3'd4
	} reg_idx_t;

	localparam logic [TIME_W-1:0]  RST_PAIR_TIME_WINDOW   = 16'd128;
	localparam logic [TIME_W-1:0]  RST_NOISE_GAP_MEAN     = 16'd160;
	localparam logic [PLANE_W-1:0] RST_LAST_CHAMBER_PLANE = 6'd24;
	localparam logic [PLANE_W-1:0] RST_PAIR_PLANE_LOW     = 6'd13;
	localparam logic [PLANE_W-1:0] RST_PAIR_PLANE_HIGH    = 6'd18;

	typedef struct packed {
		logic [TIME_W-1:0]  pair_time_window;
		logic [TIME_W-1:0]  noise_gap_mean;
		logic [PLANE_W-1:0] last_chamber_plane;
		logic [PLANE_W-1:0] pair_plane_low;
		logic [PLANE_W-1:0] pair_plane_high;
	} cfg_t;

	// One closed cluster (or one pass-through hit) with what the decision needs.
	typedef struct packed {
		logic                      is_pass;
		logic [IDX_W-1:0]          pass_idx;
		logic [CNT_W-1:0]          n;
		logic [PLANE_W-1:0]        plane;
		logic signed [POS_W-1:0]   fpos;
		logic signed [POS_W-1:0]   lpos;
		logic [DRIFT_W-1:0]        fdrift;
		logic [DRIFT_W-1:0]        ldrift;
		logic [TIME_W-1:0]         ftime;
		logic [TIME_W-1:0]         ltime;
		logic [GAP_W-1:0]          gap_sum;
		logic                      run_last;
		logic                      event_done;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
		logic room2;
	} q_stat_t;

	typedef enum logic {
		FR_IDLE,
		FR_PUSH_B
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DEC1,
		BK_DEC2,
		BK_EMIT
	} bk_state_t;

endpackage

/* design/whd_if.sv */
// Channel interfaces of the wire hit declusterer: hit words in, decision words out.
// Depends on whd_pkg for the field widths.
interface whd_hit_if import whd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    hit_index;
	logic [PLANE_W-1:0]  plane;
	logic [WIRE_W-1:0]   wire_req;
	logic [TIME_W-1:0]   hit_time;
	logic signed [POS_W-1:0] position;
	logic [DRIFT_W-1:0]  drift;
	logic                event_end;

	modport source(output valid, hit_index, plane, wire_req, hit_time, position, drift,
		event_end, input ready);
	modport sink(input valid, hit_index, plane, wire_req, hit_time, position, drift,
		event_end, output ready);
endinterface

interface whd_res_if import whd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] kept_index;
	logic             keep;
	logic             run_last;
	logic             event_done;

	modport source(output valid, kept_index, keep, run_last, event_done, input ready);
	modport sink(input valid, kept_index, keep, run_last, event_done, output ready);
endinterface

/* design/whd_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module whd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/whd_queue.sv */
// Short command queue between the declusterer front and back.
// Depends on whd_pkg for cmd_t and q_stat_t.
module whd_queue import whd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_data,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + Q_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + Q_AW'(1);
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	assign head           = mem_q[rp_q];
	assign stat.not_empty = (cnt_q != '0);
	assign stat.room2     = (cnt_q <= (Q_AW+1)'(Q_DEPTH - 2));

endmodule

/* design/whd_front.sv */
// Front of the declusterer: takes hit words, tracks the open cluster, writes hit
// indices to the ring and queues one command per closed cluster or pass-through hit.
// Depends on whd_pkg and whd_if.
module whd_front import whd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	whd_hit_if.sink            hit,
	input  q_stat_t            q_stat,
	output logic               push,
	output cmd_t               push_data,
	output logic               ring_we,
	output logic [RING_AW-1:0] ring_waddr,
	output logic [IDX_W-1:0]   ring_wdata,
	input  logic               ring_rel
);

	fr_state_t st_q, st_d;

	logic [CNT_W-1:0]        count_q;
	logic [PLANE_W-1:0]      open_plane_q;
	logic [WIRE_W-1:0]       open_wire_q;
	logic signed [POS_W-1:0] first_pos_q;
	logic [DRIFT_W-1:0]      first_drift_q;
	logic [TIME_W-1:0]       first_time_q;
	logic signed [POS_W-1:0] latest_pos_q;
	logic [DRIFT_W-1:0]      latest_drift_q;
	logic [TIME_W-1:0]       latest_time_q;
	logic [GAP_W-1:0]        gap_sum_q;
	logic [RING_AW-1:0]      wp_q;
	logic [RING_AW:0]        ring_used_q;
	logic                    b_pass_q;
	logic                    b_end_q;
	logic [IDX_W-1:0]        b_idx_q;

	logic               acc;
	logic               is_pass;
	logic [WIRE_W:0]    wdiff;
	logic               join_ok;
	logic               close_old;
	logic               fresh;
	logic [CNT_W-1:0]   new_count;
	logic               b_valid;
	logic [TIME_W-1:0]  gap;
	cmd_t               snap;

	assign is_pass   = (hit.plane > cfg.last_chamber_plane);
	assign wdiff     = {1'b0, hit.wire_req} - {1'b0, open_wire_q};
	assign join_ok   = (hit.plane == open_plane_q) && ($signed(wdiff) <= 9'sd1);
	assign close_old = (count_q != '0) && (is_pass || !join_ok);
	assign fresh     = (count_q == '0) || close_old;
	assign new_count = fresh ? CNT_W'(1) : count_q + CNT_W'(1);
	assign b_valid   = is_pass || (new_count == CNT_W'(MAX_CLUSTER)) || hit.event_end;
	assign gap       = (latest_time_q > hit.hit_time) ? latest_time_q - hit.hit_time
		: hit.hit_time - latest_time_q;

	assign hit.ready = (st_q == FR_IDLE) && q_stat.room2
		&& (ring_used_q < (RING_AW+1)'(RING_DEPTH));
	assign acc = hit.valid && hit.ready;

	assign ring_we    = acc && !is_pass;
	assign ring_waddr = wp_q;
	assign ring_wdata = hit.hit_index;

	// The open cluster as the registers hold it now.
	always_comb begin
		snap            = '0;
		snap.n          = count_q;
		snap.plane      = open_plane_q;
		snap.fpos       = first_pos_q;
		snap.lpos       = latest_pos_q;
		snap.fdrift     = first_drift_q;
		snap.ldrift     = latest_drift_q;
		snap.ftime      = first_time_q;
		snap.ltime      = latest_time_q;
		snap.gap_sum    = gap_sum_q;
	end

	always_comb begin
		st_d      = st_q;
		push      = 1'b0;
		push_data = snap;
		unique case (st_q)
			FR_IDLE: begin
				if (acc) begin
					push               = close_old;
					push_data.run_last = !b_valid;
					if (b_valid) begin
						st_d = FR_PUSH_B;
					end
				end
			end
			FR_PUSH_B: begin
				push = 1'b1;
				if (b_pass_q) begin
					push_data          = '0;
					push_data.is_pass  = 1'b1;
					push_data.pass_idx = b_idx_q;
					push_data.n        = CNT_W'(1);
				end
				push_data.run_last   = 1'b1;
				push_data.event_done = b_end_q;
				st_d = FR_IDLE;
			end
			default: st_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FR_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			open_plane_q   <= '0;
			open_wire_q    <= '0;
			first_pos_q    <= '0;
			first_drift_q  <= '0;
			first_time_q   <= '0;
			latest_pos_q   <= '0;
			latest_drift_q <= '0;
			latest_time_q  <= '0;
			gap_sum_q      <= '0;
			wp_q           <= '0;
			ring_used_q    <= '0;
			b_pass_q       <= 1'b0;
			b_end_q        <= 1'b0;
			b_idx_q        <= '0;
		end else begin
			ring_used_q <= ring_used_q + (RING_AW+1)'(ring_we) - (RING_AW+1)'(ring_rel);
			if (acc) begin
				b_pass_q <= is_pass;
				b_end_q  <= hit.event_end;
				b_idx_q  <= hit.hit_index;
				if (is_pass) begin
					if (close_old) begin
						count_q <= '0;
					end
				end else begin
					wp_q           <= wp_q + RING_AW'(1);
					count_q        <= new_count;
					open_wire_q    <= hit.wire_req;
					latest_pos_q   <= hit.position;
					latest_drift_q <= hit.drift;
					latest_time_q  <= hit.hit_time;
					if (fresh) begin
						open_plane_q  <= hit.plane;
						first_pos_q   <= hit.position;
						first_drift_q <= hit.drift;
						first_time_q  <= hit.hit_time;
						gap_sum_q     <= '0;
					end else begin
						gap_sum_q <= gap_sum_q + GAP_W'(gap);
					end
				end
			end else if (st_q == FR_PUSH_B && !b_pass_q) begin
				count_q <= '0;
			end
		end
	end

	a_ring_rel_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ring_rel |-> ring_used_q != '0)
		else $error("ring released while empty");

	a_cluster_not_full_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> count_q < CNT_W'(MAX_CLUSTER))
		else $error("full cluster still open at accept");

endmodule

/* design/whd_back.sv */
// Back of the declusterer: pops cluster commands, works out the keep decisions and
// emits one decision word per hit, reading the hit indices back from the ring.
// Depends on whd_pkg and whd_if.
module whd_back import whd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               q_head,
	input  q_stat_t            q_stat,
	output logic               pop,
	output logic               ring_re,
	output logic [RING_AW-1:0] ring_raddr,
	input  logic [IDX_W-1:0]   ring_rdata,
	output logic               ring_rel,
	whd_res_if.source          result
);

	bk_state_t st_q, st_d;

	cmd_t                     cmd_q;
	logic [CNT_W-1:0]         i_q;
	logic [RING_AW-1:0]       rp_q;
	logic signed [DPOS_W-1:0] dpos_q;
	logic [TIME_W-1:0]        dt_q;
	logic [GAP_W:0]           thresh_q;
	logic                     kf_q;
	logic                     kl_q;

	logic                     s1_valid_q;
	logic                     s1_keep_q;
	logic                     s1_pass_q;
	logic [IDX_W-1:0]         s1_idx_q;
	logic                     s1_run_last_q;
	logic                     s1_event_done_q;

	logic                     res_valid_q;
	logic [IDX_W-1:0]         res_idx_q;
	logic                     res_keep_q;
	logic                     res_run_last_q;
	logic                     res_event_done_q;

	logic                     s1_move;
	logic                     s1_free;
	logic                     issue;
	logic                     last_i;
	logic                     cur_keep;
	logic [CNT_W-1:0]         n_m1;

	logic signed [26:0]       d9;
	logic signed [26:0]       f20;
	logic signed [26:0]       l20;
	logic signed [DPOS_W:0]   dpos_x;
	logic signed [DPOS_W:0]   f5;
	logic signed [DPOS_W:0]   l5;
	logic                     fu, lu, fl, ll;
	logic                     in_range;
	logic                     dec_kf;
	logic                     dec_kl;

	assign n_m1     = cmd_q.n - CNT_W'(1);
	assign s1_move  = s1_valid_q && (!res_valid_q || result.ready);
	assign s1_free  = !s1_valid_q || s1_move;
	assign last_i   = cmd_q.is_pass || (i_q == n_m1);
	assign issue    = (st_q == BK_EMIT) && s1_free;
	assign cur_keep = (i_q == '0) ? kf_q : ((i_q == n_m1) ? kl_q : 1'b0);

	assign ring_re    = issue && !cmd_q.is_pass;
	assign ring_raddr = rp_q;
	assign ring_rel   = ring_re;

	// Drift bounds against the position difference; 20*drift > 9*dpos and 5*drift > dpos.
	assign d9     = ({{(27-DPOS_W){dpos_q[DPOS_W-1]}}, dpos_q} <<< 3)
		+ {{(27-DPOS_W){dpos_q[DPOS_W-1]}}, dpos_q};
	assign f20    = $signed(27'(cmd_q.fdrift) * 27'd20);
	assign l20    = $signed(27'(cmd_q.ldrift) * 27'd20);
	assign dpos_x = {dpos_q[DPOS_W-1], dpos_q};
	assign f5     = $signed((DPOS_W+1)'(cmd_q.fdrift) * (DPOS_W+1)'(5));
	assign l5     = $signed((DPOS_W+1)'(cmd_q.ldrift) * (DPOS_W+1)'(5));
	assign fu     = f20 > d9;
	assign lu     = l20 > d9;
	assign fl     = f5 > dpos_x;
	assign ll     = l5 > dpos_x;
	assign in_range = (cmd_q.plane >= cfg.pair_plane_low)
		&& (cmd_q.plane <= cfg.pair_plane_high);

	always_comb begin
		dec_kf = 1'b1;
		dec_kl = 1'b1;
		if (cmd_q.n == CNT_W'(2)) begin
			if ((fu && ll) || (fl && lu)) begin
				if (cmd_q.fdrift > cmd_q.ldrift) begin
					dec_kf = 1'b0;
				end else begin
					dec_kl = 1'b0;
				end
			end else if ((dt_q < cfg.pair_time_window) && in_range) begin
				dec_kf = 1'b0;
				dec_kl = 1'b0;
			end
		end else if ({1'b0, cmd_q.gap_sum} < thresh_q) begin
			dec_kf = 1'b0;
			dec_kl = 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (q_stat.not_empty) begin
					pop = 1'b1;
					if (q_head.is_pass || q_head.n < CNT_W'(2)) begin
						st_d = BK_EMIT;
					end else begin
						st_d = BK_DEC1;
					end
				end
			end
			BK_DEC1: st_d = BK_DEC2;
			BK_DEC2: st_d = BK_EMIT;
			BK_EMIT: begin
				if (issue && last_i) begin
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
			i_q   <= '0;
			kf_q  <= 1'b1;
			kl_q  <= 1'b1;
		end
		if (st_q == BK_DEC1) begin
			dpos_q   <= DPOS_W'(cmd_q.lpos) - DPOS_W'(cmd_q.fpos);
			dt_q     <= (cmd_q.ftime > cmd_q.ltime) ? cmd_q.ftime - cmd_q.ltime
				: cmd_q.ltime - cmd_q.ftime;
			// Noise threshold: mean gap times the number of neighbor gaps.
			thresh_q <= (GAP_W+1)'(cfg.noise_gap_mean) * (GAP_W+1)'(n_m1);
		end
		if (st_q == BK_DEC2) begin
			kf_q <= dec_kf;
			kl_q <= dec_kl;
		end
		if (issue) begin
			i_q             <= i_q + CNT_W'(1);
			s1_keep_q       <= cur_keep;
			s1_pass_q       <= cmd_q.is_pass;
			s1_idx_q        <= cmd_q.pass_idx;
			s1_run_last_q   <= last_i && cmd_q.run_last;
			s1_event_done_q <= last_i && cmd_q.event_done;
		end
		if (s1_move) begin
			res_idx_q        <= s1_pass_q ? s1_idx_q : ring_rdata;
			res_keep_q       <= s1_keep_q;
			res_run_last_q   <= s1_run_last_q;
			res_event_done_q <= s1_event_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ring_re) begin
				rp_q <= rp_q + RING_AW'(1);
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = res_valid_q;
	assign result.kept_index = res_idx_q;
	assign result.keep       = res_keep_q;
	assign result.run_last   = res_run_last_q;
	assign result.event_done = res_event_done_q;

	a_emit_in_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_EMIT) |-> (cmd_q.is_pass || (cmd_q.n != '0 && i_q < cmd_q.n)))
		else $error("emit index beyond cluster size");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_move) |-> !ring_re)
		else $error("ring read while a read word is still held");

	a_decide_multi: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_DEC2) |-> (!cmd_q.is_pass && cmd_q.n >= CNT_W'(2)))
		else $error("decision pass for a single-hit command");

endmodule

/* design/wire_hit_declusterer.sv */
// Top level of the wire hit declusterer: APB register bank, front, command queue,
// back and the hit index ring. Depends on whd_pkg, whd_if, whd_ram, whd_queue,
// whd_front and whd_back.
//
//  Channel  Dir  Handshake         Word
//  hit      in   valid/ready       hit_index, plane, wire_req, hit_time, position,
//                                  drift, event_end
//  result   out  valid/ready       kept_index, keep, run_last, event_done
//  apb      in   psel/penable      5 register writes and reads, pready always high
//
// The front takes a hit word every cycle while hits only join or close clusters and the
// queue and the ring have room; a hit that flushes itself (pass-through, event end or a
// full cluster) holds ready low while the front queues that cluster or pass-through word
// in its push state. The back pops a command, passes through the decision states DEC1 and
// DEC2 for clusters of two or more hits, then issues one decision word per cycle, while
// the output is not stalled, through a ring read and an output register. Reset is
// asynchronous and active low; it restores the register defaults and empties the open
// cluster, the queue and the ring. A stalled result port backs up into the queue and the
// ring and finally drops hit ready; the front keeps accepting hits while earlier decision words still wait.
module wire_hit_declusterer import whd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	whd_hit_if.sink           hit,
	whd_res_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t               cfg_q;
	logic               cfg_wr;
	logic [2:0]         reg_sel;

	cmd_t               push_data;
	cmd_t               q_head;
	q_stat_t            q_stat;
	logic               push;
	logic               pop;

	logic               ring_we;
	logic [RING_AW-1:0] ring_waddr;
	logic [IDX_W-1:0]   ring_wdata;
	logic               ring_re;
	logic [RING_AW-1:0] ring_raddr;
	logic [IDX_W-1:0]   ring_rdata;
	logic               ring_rel;

	// Register bank. A write lands in the access phase; unknown addresses are ignored.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pair_time_window   <= RST_PAIR_TIME_WINDOW;
			cfg_q.noise_gap_mean     <= RST_NOISE_GAP_MEAN;
			cfg_q.last_chamber_plane <= RST_LAST_CHAMBER_PLANE;
			cfg_q.pair_plane_low     <= RST_PAIR_PLANE_LOW;
			cfg_q.pair_plane_high    <= RST_PAIR_PLANE_HIGH;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_PAIR_TIME_WINDOW:   cfg_q.pair_time_window   <= pwdata[TIME_W-1:0];
				REG_NOISE_GAP_MEAN:     cfg_q.noise_gap_mean     <= pwdata[TIME_W-1:0];
				REG_LAST_CHAMBER_PLANE: cfg_q.last_chamber_plane <= pwdata[PLANE_W-1:0];
				REG_PAIR_PLANE_LOW:     cfg_q.pair_plane_low     <= pwdata[PLANE_W-1:0];
				REG_PAIR_PLANE_HIGH:    cfg_q.pair_plane_high    <= pwdata[PLANE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PAIR_TIME_WINDOW:   prdata = APB_DW'(cfg_q.pair_time_window);
			REG_NOISE_GAP_MEAN:     prdata = APB_DW'(cfg_q.noise_gap_mean);
			REG_LAST_CHAMBER_PLANE: prdata = APB_DW'(cfg_q.last_chamber_plane);
			REG_PAIR_PLANE_LOW:     prdata = APB_DW'(cfg_q.pair_plane_low);
			REG_PAIR_PLANE_HIGH:    prdata = APB_DW'(cfg_q.pair_plane_high);
			default:                prdata = '0;
		endcase
	end

	// The front sorts hits into clusters and queues one command per closed cluster or pass-through hit.
	whd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hit        (hit),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_rel   (ring_rel)
	);

	whd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// Hit indices of every chamber hit, in arrival order; the back reads them in order.
	whd_ram #(
		.WIDTH (IDX_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// The back decides each cluster and emits one decision word per hit.
	whd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_head     (q_head),
		.q_stat     (q_stat),
		.pop        (pop),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.ring_rel   (ring_rel),
		.result     (result)
	);

endmodule
